// ----- design/mbr_pkg.sv -----
// shared types and constants for the msb-first bit reader
// no dependencies; imported by mbr_align and msb_first_bit_reader
package mbr_pkg;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PEEK   = 2'd1,
    OP_FETCH  = 2'd2,
    OP_SETPOS = 2'd3
  } mbr_op_t;

  localparam int NUM_BANKS = 8;   // one bank per byte lane of an eight-byte row
  localparam int BANK_W    = 3;   // bank select bits
  localparam int WIN_BYTES = 5;   // 32 bits from any bit offset span five bytes
  localparam int WIN_W     = WIN_BYTES * 8;
  localparam int MAX_BITS  = 32;
  localparam int COUNT_W   = 6;
  localparam int ADDR_W    = 10;
  localparam int POS_W     = 14;
  localparam int BITS_W    = 32;

  // read window handed from the request stage to the aligner
  typedef struct packed {
    logic [2:0]           bit_off;   // bit offset inside the first byte
    logic [BANK_W-1:0]    bank_lo;   // bank holding the first byte
    logic [COUNT_W-1:0]   count;     // bits to return, zero for set position
    logic [WIN_BYTES-1:0] byte_ok;   // byte lies inside the buffer
  } mbr_win_t;

endpackage

// ----- design/mbr_bank.sv -----
// one byte-wide bank of the buffer: one write port, one registered read port
// uses mbr_pkg nowhere; instantiated by msb_first_bit_reader
module mbr_bank #(
  parameter int DEPTH = 128,
  parameter int RW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [RW-1:0] wr_row,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [RW-1:0] rd_row,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/mbr_align.sv -----
// picks the five window bytes out of the banks and aligns the requested bits
// depends on mbr_pkg
module mbr_align (
  input  logic [mbr_pkg::NUM_BANKS-1:0][7:0] bank_data,
  input  mbr_pkg::mbr_win_t                  win,
  output logic [mbr_pkg::BITS_W-1:0]         bits
);
  import mbr_pkg::*;

  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  shifted;
  logic [BITS_W-1:0] top;
  logic [BANK_W-1:0] sel;

  always_comb begin
    window = '0;
    sel    = '0;
    // first byte lands in the top bits of the window
    for (int j = 0; j < WIN_BYTES; j++) begin
      sel = win.bank_lo + BANK_W'(j);
      window[WIN_W-1-8*j -: 8] = bank_data[sel] & {8{win.byte_ok[j]}};
    end
    shifted = window << win.bit_off;
    top     = shifted[WIN_W-1 -: BITS_W];
    if (win.count == '0) begin
      bits = '0;
    end else begin
      bits = top >> (COUNT_W'(MAX_BITS) - win.count);
    end
  end

endmodule

// ----- design/msb_first_bit_reader.sv -----
// msb-first bit reader: items pass the request stage, then the output register;
// throughput one item per cycle unless out_tready stalls the output; the banked
// buffer gives every item its five-byte window in a single read of all eight banks
// reset clears the bit position and the pipeline valids; the byte buffer
// keeps its contents and is undefined until loaded
module msb_first_bit_reader #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // byte_address[9:0], byte_value[17:10],
                                  // bit_count[23:18], new_position[37:24], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // bits[31:0], position_after[45:32],
                                  // overrun[46], zero pad
);
  import mbr_pkg::*;

  localparam int unsigned EndBit = BUFFER_BYTES * 8;
  localparam int PW     = $clog2(EndBit + 1);          // position register width
  localparam int BYTE_W = PW - 3;
  localparam int DEPTH  = (BUFFER_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int RW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // input fields
  mbr_op_t            op;
  logic [ADDR_W-1:0]  byte_address;
  logic [7:0]         byte_value;
  logic [COUNT_W-1:0] bit_count;
  logic [POS_W-1:0]   new_position;

  assign op           = mbr_op_t'(in_tuser);
  assign byte_address = in_tdata[9:0];
  assign byte_value   = in_tdata[17:10];
  assign bit_count    = in_tdata[23:18];
  assign new_position = in_tdata[37:24];

  // pipeline state
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  mbr_win_t         s1_win_r, s1_win_nxt;
  logic             s1_over_r, s1_over_nxt;
  logic [POS_W-1:0] s1_pos_r;
  logic             out_valid_r;
  logic [BITS_W-1:0] out_bits_r;
  logic [POS_W-1:0] out_pos_r;
  logic             out_over_r;

  logic in_acc, s1_free, out_adv;

  // output register frees up when empty or taken; the request stage
  // frees up when empty or moving into the output register
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_adv;
  assign in_tready = s1_free;
  assign in_acc    = in_tvalid && in_tready;

  // request-side arithmetic, from the current position register and the input fields
  logic [COUNT_W-1:0] cnt_sat;
  logic [PW:0]        pos_sum;
  logic               past_end;
  logic [PW-1:0]      fetch_pos;
  logic               np_over;
  logic [PW-1:0]      np_sat;
  logic [BYTE_W-1:0]  byte0;
  logic [RW-1:0]      row0;
  logic [RW-1:0]      rd_row [NUM_BANKS];
  logic [WIN_BYTES-1:0] byte_ok;

  always_comb begin
    cnt_sat   = (bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count;
    pos_sum   = (PW+1)'(pos_r) + (PW+1)'(cnt_sat);
    // overrun on a read means the last requested bit lies at or past the end
    past_end  = pos_sum > (PW+1)'(EndBit);
    fetch_pos = past_end ? PW'(EndBit) : PW'(pos_sum);
    np_over   = 32'(new_position) > EndBit;
    np_sat    = np_over ? PW'(EndBit) : PW'(new_position);
    byte0     = pos_r[PW-1:3];
    row0      = RW'(pos_r >> 6);
    // banks below the first byte's lane serve the following row
    for (int k = 0; k < NUM_BANKS; k++) begin
      rd_row[k] = (BANK_W'(k) >= byte0[BANK_W-1:0]) ? row0 : row0 + RW'(1);
    end
    for (int j = 0; j < WIN_BYTES; j++) begin
      byte_ok[j] = (32'(byte0) + 32'(j)) < 32'(BUFFER_BYTES);
    end
  end

  // item decode
  logic wr_en, rd_en;

  always_comb begin
    pos_nxt      = pos_r;
    s1_valid_nxt = s1_valid_r;
    s1_win_nxt   = s1_win_r;
    s1_over_nxt  = s1_over_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    if (s1_free) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_win_nxt.bit_off = pos_r[2:0];
      s1_win_nxt.bank_lo = byte0[BANK_W-1:0];
      s1_win_nxt.count   = cnt_sat;
      s1_win_nxt.byte_ok = byte_ok;
      s1_over_nxt        = past_end;
      unique case (op)
        OP_LOAD: begin
          // loads past the buffer are dropped
          wr_en = 32'(byte_address) < 32'(BUFFER_BYTES);
        end
        OP_PEEK: begin
          rd_en        = 1'b1;
          s1_valid_nxt = 1'b1;
        end
        OP_FETCH: begin
          rd_en        = 1'b1;
          s1_valid_nxt = 1'b1;
          pos_nxt      = fetch_pos;
        end
        OP_SETPOS: begin
          s1_valid_nxt     = 1'b1;
          s1_win_nxt.count = '0;
          s1_over_nxt      = np_over;
          pos_nxt          = np_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // the position reported with a result is the one left by its item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_win_r  <= s1_win_nxt;
      s1_over_r <= s1_over_nxt;
      s1_pos_r  <= POS_W'(pos_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // banked byte buffer
  logic [NUM_BANKS-1:0][7:0] bank_data;
  logic [RW-1:0]             wr_row;

  assign wr_row = RW'(byte_address >> 3);

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    mbr_bank #(
      .DEPTH (DEPTH),
      .RW    (RW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en && (byte_address[BANK_W-1:0] == BANK_W'(k))),
      .wr_row  (wr_row),
      .wr_data (byte_value),
      .rd_en   (rd_en),
      .rd_row  (rd_row[k]),
      .rd_data (bank_data[k])
    );
  end

  // alignment of the window into the result bits
  logic [BITS_W-1:0] s1_bits;

  mbr_align u_align (
    .bank_data (bank_data),
    .win       (s1_win_r),
    .bits      (s1_bits)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_bits_r <= s1_bits;
      out_pos_r  <= s1_pos_r;
      out_over_r <= s1_over_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_over_r, out_pos_r, out_bits_r};

  // checks

  // position never runs past the end of the buffer
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(EndBit))
    else $error("bit position beyond buffer end");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_LOAD) |=> !s1_valid_r)
    else $error("load item produced a result");

  // a held result in the request stage blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("item accepted while request stage stalled");

  // a result waiting on the output keeps its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule
